/* rtl/core/sat_pkg.sv */
// Shared types, constants and helpers for the summed-area table unit.
// Used by the controller, the datapath and the top level; no dependencies.
package sat_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int PIXEL_BITS = 16;

    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int ROW_BITS  = $clog2(MAX_HEIGHT);
    localparam int ADDR_BITS = ROW_BITS + COL_BITS;
    localparam int DIM_BITS  = 9;
    localparam int SUM_BITS  = 32;
    localparam int RUN_BITS  = 24;
    localparam int STAT_BITS = 2;

    typedef logic [DIM_BITS-1:0]  dim_t;
    typedef logic [SUM_BITS-1:0]  sum_t;
    typedef logic [ADDR_BITS-1:0] addr_t;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } cfg_index_t;

    // Result status codes.
    localparam logic [STAT_BITS-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_RANGE      = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_NOT_LOADED = 2'd2;

    // Input function codes.
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_RD,
        S_LD_WR,
        S_Q_CHECK,
        S_Q_RD0,
        S_Q_RD1,
        S_Q_RD2,
        S_Q_RD3,
        S_Q_SUM,
        S_Q_OUT
    } state_t;

    typedef struct packed {
        logic       capture;
        logic       ld_prep;
        logic       ld_commit;
        logic       q_check;
        logic       q_read;
        logic [1:0] q_term;
        logic       result_load;
    } sat_cmd_t;

    typedef struct packed {
        logic check_ok;
        logic out_busy;
    } sat_stat_t;

    // A dimension of zero acts as one, anything above the maximum as the maximum.
    function automatic dim_t clamp_dim(input dim_t v, input dim_t maxv);
        dim_t r;
        if (v == '0)
        begin
            r = dim_t'(1);
        end
        else if (v > maxv)
        begin
            r = maxv;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

/* rtl/core/sat_ram.sv */
// Single-port table memory with registered read data.
// Generic; widths default from sat_pkg.
module sat_ram
    import sat_pkg::*;
#(
    parameter int AW = ADDR_BITS,
    parameter int DW = SUM_BITS
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/sat_ctrl.sv */
// Sequencing state machine for loads and queries.
// Depends on sat_pkg for the state, command and status types.
module sat_ctrl
    import sat_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      func,
    output logic      in_ready,
    input  sat_stat_t stat,
    output sat_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (func == FUNC_QUERY) ? S_Q_CHECK : S_LD_RD;
                end
            end
            S_LD_RD:   state_next = S_LD_WR;
            S_LD_WR:   state_next = S_IDLE;
            S_Q_CHECK: state_next = stat.check_ok ? S_Q_RD0 : S_Q_OUT;
            S_Q_RD0:   state_next = S_Q_RD1;
            S_Q_RD1:   state_next = S_Q_RD2;
            S_Q_RD2:   state_next = S_Q_RD3;
            S_Q_RD3:   state_next = S_Q_SUM;
            S_Q_SUM:   state_next = S_Q_OUT;
            S_Q_OUT:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_LD_RD:   cmd.ld_prep   = 1'b1;
            S_LD_WR:   cmd.ld_commit = 1'b1;
            S_Q_CHECK: cmd.q_check   = 1'b1;
            S_Q_RD0:
            begin
                cmd.q_read = 1'b1;
                cmd.q_term = 2'd0;
            end
            S_Q_RD1:
            begin
                cmd.q_read = 1'b1;
                cmd.q_term = 2'd1;
            end
            S_Q_RD2:
            begin
                cmd.q_read = 1'b1;
                cmd.q_term = 2'd2;
            end
            S_Q_RD3:
            begin
                cmd.q_read = 1'b1;
                cmd.q_term = 2'd3;
            end
            S_Q_SUM:   cmd = '0;
            S_Q_OUT:   cmd.result_load = !stat.out_busy;
            default:   cmd = '0;
        endcase
    end

endmodule

/* rtl/core/sat_datapath.sv */
// Datapath: configuration, load position, table memory, query accumulation
// and the output register. Depends on sat_pkg and sat_ram.
module sat_datapath
    import sat_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  sat_cmd_t              cmd,
    output sat_stat_t             stat,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [DIM_BITS-1:0]   cfg_data,
    input  logic [PIXEL_BITS-1:0] pixel,
    input  logic [DIM_BITS-1:0]   rect_x,
    input  logic [DIM_BITS-1:0]   rect_y,
    input  logic [DIM_BITS-1:0]   rect_w,
    input  logic [DIM_BITS-1:0]   rect_h,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SUM_BITS-1:0]   area_sum,
    output logic [STAT_BITS-1:0]  status
);

    localparam dim_t MAX_W_DIM = dim_t'(MAX_WIDTH);
    localparam dim_t MAX_H_DIM = dim_t'(MAX_HEIGHT);

    // Captured beat.
    logic [PIXEL_BITS-1:0] pixel_reg;
    dim_t                  x_reg, y_reg, w_rect_reg, h_rect_reg;

    // Configuration and load state.
    dim_t                  width_reg, width_next;
    dim_t                  height_reg, height_next;
    logic [COL_BITS-1:0]   col_reg, col_next;
    logic [ROW_BITS-1:0]   row_reg, row_next;
    logic [RUN_BITS-1:0]   run_reg, run_next;
    logic                  complete_reg, complete_next;
    logic                  above_zero_reg, above_zero_next;

    // Query state.
    logic [DIM_BITS:0]     x_end_reg, y_end_reg;
    logic [STAT_BITS-1:0]  qstat_reg, qstat_next;
    sum_t                  acc_reg, acc_next;
    logic                  pend_reg, pend_sub_reg, pend_zero_reg;

    // Output register.
    logic                  out_valid_reg;
    sum_t                  out_sum_reg;
    logic [STAT_BITS-1:0]  out_stat_reg;

    // Memory port.
    logic                  mem_we;
    addr_t                 mem_addr;
    sum_t                  mem_wdata;
    sum_t                  mem_rdata;

    logic                  restart;
    logic [COL_BITS-1:0]   pos_col;
    logic [ROW_BITS-1:0]   pos_row;
    logic [RUN_BITS-1:0]   run_base;
    logic [ROW_BITS-1:0]   above_row;
    logic [DIM_BITS-1:0]   col_inc;
    logic [DIM_BITS-1:0]   row_inc;
    logic [DIM_BITS:0]     x_end_calc, y_end_calc;
    dim_t                  term_r, term_c, term_r_m1, term_c_m1;
    logic                  term_zero, term_sub;
    addr_t                 term_addr;
    sum_t                  term_val;

    sat_ram u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Load position after an implied restart (completed image or stale position).
    assign restart   = complete_reg
                    || ({1'b0, col_reg} >= width_reg)
                    || ({1'b0, row_reg} >= height_reg);
    assign pos_col   = restart ? '0 : col_reg;
    assign pos_row   = restart ? '0 : row_reg;
    assign run_base  = restart ? '0 : run_reg;
    assign above_row = pos_row - ROW_BITS'(1);
    assign col_inc   = {1'b0, col_reg} + dim_t'(1);
    assign row_inc   = {1'b0, row_reg} + dim_t'(1);

    assign x_end_calc = {1'b0, x_reg} + {1'b0, w_rect_reg};
    assign y_end_calc = {1'b0, y_reg} + {1'b0, h_rect_reg};

    // Query terms in order: bottom-right, top-left, bottom-left, top-right.
    always_comb
    begin
        case (cmd.q_term)
            2'd0:
            begin
                term_r   = y_end_reg[DIM_BITS-1:0];
                term_c   = x_end_reg[DIM_BITS-1:0];
                term_sub = 1'b0;
            end
            2'd1:
            begin
                term_r   = y_reg;
                term_c   = x_reg;
                term_sub = 1'b0;
            end
            2'd2:
            begin
                term_r   = y_end_reg[DIM_BITS-1:0];
                term_c   = x_reg;
                term_sub = 1'b1;
            end
            default:
            begin
                term_r   = y_reg;
                term_c   = x_end_reg[DIM_BITS-1:0];
                term_sub = 1'b1;
            end
        endcase
    end

    assign term_zero = (term_r == '0) || (term_c == '0);
    assign term_r_m1 = term_r - dim_t'(1);
    assign term_c_m1 = term_c - dim_t'(1);
    assign term_addr = {term_r_m1[ROW_BITS-1:0], term_c_m1[COL_BITS-1:0]};

    always_comb
    begin
        mem_we    = cmd.ld_commit;
        mem_wdata = (above_zero_reg ? '0 : mem_rdata) + {{(SUM_BITS-RUN_BITS){1'b0}}, run_reg};
        if (cmd.ld_commit)
        begin
            mem_addr = {row_reg, col_reg};
        end
        else if (cmd.ld_prep)
        begin
            mem_addr = {above_row, pos_col};
        end
        else
        begin
            mem_addr = term_addr;
        end
    end

    // Configuration and load bookkeeping.
    always_comb
    begin
        width_next      = width_reg;
        height_next     = height_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        run_next        = run_reg;
        complete_next   = complete_reg;
        above_zero_next = above_zero_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_WIDTH:  width_next  = clamp_dim(cfg_data, MAX_W_DIM);
                CFG_HEIGHT: height_next = clamp_dim(cfg_data, MAX_H_DIM);
            endcase
            col_next      = '0;
            row_next      = '0;
            run_next      = '0;
            complete_next = 1'b0;
        end
        else if (cmd.ld_prep)
        begin
            col_next        = pos_col;
            row_next        = pos_row;
            run_next        = run_base + {{(RUN_BITS-PIXEL_BITS){1'b0}}, pixel_reg};
            complete_next   = 1'b0;
            above_zero_next = (pos_row == '0);
        end
        else if (cmd.ld_commit)
        begin
            if (col_inc >= width_reg)
            begin
                col_next = '0;
                run_next = '0;
                if (row_inc >= height_reg)
                begin
                    row_next      = '0;
                    complete_next = 1'b1;
                end
                else
                begin
                    row_next = row_inc[ROW_BITS-1:0];
                end
            end
            else
            begin
                col_next = col_inc[COL_BITS-1:0];
            end
        end
    end

    // Query range check and four-term accumulation.
    always_comb
    begin
        if (!complete_reg)
        begin
            qstat_next = ST_NOT_LOADED;
        end
        else if ((x_end_calc > {1'b0, width_reg}) || (y_end_calc > {1'b0, height_reg}))
        begin
            qstat_next = ST_RANGE;
        end
        else
        begin
            qstat_next = ST_OK;
        end
    end

    assign term_val = pend_zero_reg ? '0 : mem_rdata;

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.q_check)
        begin
            acc_next = '0;
        end
        else if (pend_reg)
        begin
            acc_next = pend_sub_reg ? (acc_reg - term_val) : (acc_reg + term_val);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pixel_reg  <= pixel;
            x_reg      <= rect_x;
            y_reg      <= rect_y;
            w_rect_reg <= rect_w;
            h_rect_reg <= rect_h;
        end
        if (cmd.q_check)
        begin
            x_end_reg <= x_end_calc;
            y_end_reg <= y_end_calc;
            qstat_reg <= qstat_next;
        end
        if (cmd.result_load)
        begin
            out_sum_reg  <= (qstat_reg == ST_OK) ? acc_reg : '0;
            out_stat_reg <= qstat_reg;
        end
        above_zero_reg <= above_zero_next;
        acc_reg        <= acc_next;
        pend_sub_reg   <= term_sub;
        pend_zero_reg  <= term_zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= MAX_W_DIM;
            height_reg    <= MAX_H_DIM;
            col_reg       <= '0;
            row_reg       <= '0;
            run_reg       <= '0;
            complete_reg  <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            run_reg      <= run_next;
            complete_reg <= complete_next;
            pend_reg     <= cmd.q_read;
            if (cmd.result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.check_ok = (qstat_next == ST_OK);
    assign stat.out_busy = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign area_sum  = out_sum_reg;
    assign status    = out_stat_reg;

endmodule

/* rtl/core/summed_area_table_unit.sv */
// Top level of the summed-area table unit: controller plus datapath.
// Depends on sat_pkg, sat_ctrl, sat_datapath and sat_ram.
//
// Pixels are loaded in raster order (func 0) and build the integral image in a
// 64K x 32 single-port table memory; a query (func 1) returns the rectangle sum
// with a status code. A load passes through the accept cycle, one read of the
// entry above, and the write. A query passes through the accept cycle, a
// range check, four table reads on the single memory port, the last
// accumulation and the result cycle, and waits in the result state while the
// output register is held by a low out_ready. A query that fails its check skips
// the reads and passes through the accept cycle, the check and the result cycle. One beat is in
// flight at a time; a finished result sits in the output register while the
// next beat is taken. The table needs no clearing pass: queries are answered
// only after the full image has been loaded.
module summed_area_table_unit
    import sat_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [DIM_BITS-1:0]   cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  func,
    input  logic [PIXEL_BITS-1:0] pixel,
    input  logic [DIM_BITS-1:0]   rect_x,
    input  logic [DIM_BITS-1:0]   rect_y,
    input  logic [DIM_BITS-1:0]   rect_w,
    input  logic [DIM_BITS-1:0]   rect_h,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SUM_BITS-1:0]   area_sum,
    output logic [STAT_BITS-1:0]  status
);

    sat_cmd_t  cmd;
    sat_stat_t stat;

    sat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sat_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel),
        .rect_x    (rect_x),
        .rect_y    (rect_y),
        .rect_w    (rect_w),
        .rect_h    (rect_h),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .area_sum  (area_sum),
        .status    (status)
    );

    // The single memory port serves one operation per cycle.
    a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.ld_prep, cmd.ld_commit, cmd.q_read}))
        else $error("table memory port driven by two operations");

    // A table write always follows the read of the entry above.
    a_commit_after_prep: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ld_commit |-> $past(cmd.ld_prep))
        else $error("load write without preceding read");

    // Only one beat is worked on at a time.
    a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("beat accepted while another is in progress");

    // An error result carries a zero sum.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> (area_sum == '0))
        else $error("nonzero sum on error status");

endmodule

/* tb/summed_area_table_unit_test.sv */
// Self-checking testbench for summed_area_table_unit: a queue-fed driver, a stalling
// result monitor and a cycle-free integral-image predictor built from sat_pkg types.
// Depends on sat_pkg and the summed_area_table_unit RTL.
module summed_area_table_unit_test;
    import sat_pkg::*;

    typedef struct {
        logic                  fn;
        logic [PIXEL_BITS-1:0] pix;
        dim_t                  x;
        dim_t                  y;
        dim_t                  w;
        dim_t                  h;
    } sat_beat_t;

    typedef struct {
        sum_t                 sum;
        logic [STAT_BITS-1:0] stat;
    } area_result_t;

    localparam int unsigned LOAD_SETTLE = 12;
    localparam int unsigned RANDOM_ITEMS = 850;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic                  cfg_index = 1'b0;
    dim_t                  cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  func = 1'b0;
    logic [PIXEL_BITS-1:0] pixel = '0;
    dim_t                  rect_x = '0;
    dim_t                  rect_y = '0;
    dim_t                  rect_w = '0;
    dim_t                  rect_h = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    sum_t                  area_sum;
    logic [STAT_BITS-1:0]  status;

    // Predictor copy of the table, load position and registers.
    bit   [SUM_BITS-1:0] table_copy [0:MAX_WIDTH*MAX_HEIGHT-1];
    logic [RUN_BITS-1:0] row_sum = '0;
    int unsigned         load_col = 0;
    int unsigned         load_row_pos = 0;
    bit                  image_ready = 1'b0;
    dim_t                width_reg = 9'd256;
    dim_t                height_reg = 9'd256;

    sat_beat_t    pixel_query_queue [$];
    area_result_t pending_sums [$];
    sat_beat_t    cur_beat;
    int unsigned  send_gap = 0;
    int unsigned  recv_stall = 0;
    bit           steady_flow = 1'b0;
    bit           counting_random = 1'b0;
    int unsigned  random_item_count = 0;
    int           mismatch_count = 0;

    function automatic int unsigned dim_in_use(dim_t v, int unsigned maxv);
        if (v == 0)
        begin
            return 1;
        end
        if (v > maxv)
        begin
            return maxv;
        end
        return 32'(v);
    endfunction

    // Entry at border coordinates: row or column zero is the implied zero border.
    function automatic sum_t table_entry(int unsigned r, int unsigned c);
        if (r == 0 || c == 0)
        begin
            return '0;
        end
        return table_copy[(r - 1) * MAX_WIDTH + (c - 1)];
    endfunction

    task automatic restart_image();
        row_sum = '0;
        load_col = 0;
        load_row_pos = 0;
        image_ready = 1'b0;
    endtask

    task automatic integral_step(sat_beat_t b);
        int unsigned  wd;
        int unsigned  ht;
        int unsigned  x0;
        int unsigned  y0;
        int unsigned  x1;
        int unsigned  y1;
        sum_t         above;
        area_result_t r;
        wd = dim_in_use(width_reg, MAX_WIDTH);
        ht = dim_in_use(height_reg, MAX_HEIGHT);
        if (b.fn == FUNC_LOAD)
        begin
            if (image_ready || load_col >= wd || load_row_pos >= ht)
            begin
                restart_image();
            end
            row_sum = row_sum + RUN_BITS'(b.pix);
            above = table_entry(load_row_pos, load_col + 1);
            table_copy[load_row_pos * MAX_WIDTH + load_col] = above + SUM_BITS'(row_sum);
            load_col++;
            if (load_col >= wd)
            begin
                load_col = 0;
                row_sum = '0;
                load_row_pos++;
                if (load_row_pos >= ht)
                begin
                    load_row_pos = 0;
                    image_ready = 1'b1;
                end
            end
        end
        else
        begin
            x0 = 32'(b.x);
            y0 = 32'(b.y);
            x1 = x0 + 32'(b.w);
            y1 = y0 + 32'(b.h);
            r.sum = '0;
            if (!image_ready)
            begin
                r.stat = ST_NOT_LOADED;
            end
            else if (x1 > wd || y1 > ht)
            begin
                r.stat = ST_RANGE;
            end
            else
            begin
                r.stat = ST_OK;
                r.sum = table_entry(y1, x1) + table_entry(y0, x0)
                      - table_entry(y1, x0) - table_entry(y0, x1);
            end
            pending_sums.push_back(r);
        end
    endtask

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR at %0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic dim_t rand_coord();
        return dim_t'($urandom_range(0, MAX_WIDTH));
    endfunction

    function automatic logic [PIXEL_BITS-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return PIXEL_BITS'($urandom);
        endcase
    endfunction

    // Loads carry random rectangle fields and queries a random pixel: both are ignored.
    task automatic push_load(logic [PIXEL_BITS-1:0] p);
        sat_beat_t b;
        b.fn = FUNC_LOAD;
        b.pix = p;
        b.x = rand_coord();
        b.y = rand_coord();
        b.w = rand_coord();
        b.h = rand_coord();
        pixel_query_queue.push_back(b);
        if (counting_random)
        begin
            random_item_count++;
        end
    endtask

    task automatic push_query(dim_t x, dim_t y, dim_t w, dim_t h);
        sat_beat_t b;
        b.fn = FUNC_QUERY;
        b.pix = rand_pixel();
        b.x = x;
        b.y = y;
        b.w = w;
        b.h = h;
        pixel_query_queue.push_back(b);
        if (counting_random)
        begin
            random_item_count++;
        end
    endtask

    task automatic push_fitted_query(int unsigned wd, int unsigned ht);
        int unsigned x;
        int unsigned y;
        x = $urandom_range(0, wd);
        y = $urandom_range(0, ht);
        push_query(dim_t'(x), dim_t'(y), dim_t'($urandom_range(0, wd - x)),
                   dim_t'($urandom_range(0, ht - y)));
    endtask

    // Sampled at the falling edge so the driver's and monitor's updates have settled.
    task automatic wait_drained();
        while (pixel_query_queue.size() != 0 || in_valid || pending_sums.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(cfg_index_t idx, dim_t val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WIDTH)
        begin
            width_reg = val;
        end
        else
        begin
            height_reg = val;
        end
        restart_image();
    endtask

    // A load leaves no result behind, so give the last one time to retire first.
    task automatic reconfigure(dim_t wr, dim_t hr);
        wait_drained();
        repeat (LOAD_SETTLE) @(posedge clk);
        if ($urandom_range(0, 1) == 0)
        begin
            write_reg(CFG_WIDTH, wr);
            write_reg(CFG_HEIGHT, hr);
        end
        else
        begin
            write_reg(CFG_HEIGHT, hr);
            write_reg(CFG_WIDTH, wr);
        end
    endtask

    task automatic run_phase(int unsigned wd, int unsigned ht, bit hold_for_results);
        int unsigned total;
        int unsigned stop;
        int unsigned kind;
        total = wd * ht;
        kind = $urandom_range(0, 7);
        stop = (kind == 0) ? $urandom_range(0, total - 1) : total;
        for (int unsigned i = 0; i < stop; i++)
        begin
            push_load(rand_pixel());
            if ($urandom_range(0, 15) == 0)
            begin
                push_fitted_query(wd, ht);
            end
        end
        if (hold_for_results)
        begin
            wait_drained();
        end
        repeat ($urandom_range(3, 10))
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                push_query(rand_coord(), rand_coord(), rand_coord(), rand_coord());
            end
            else
            begin
                push_fitted_query(wd, ht);
            end
        end
        // A load after completion starts a new image, so queries fall back to not loaded.
        if (kind == 1)
        begin
            repeat ($urandom_range(1, 3)) push_load(rand_pixel());
            push_fitted_query(wd, ht);
        end
    endtask

    summed_area_table_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .pixel     (pixel),
        .rect_x    (rect_x),
        .rect_y    (rect_y),
        .rect_w    (rect_w),
        .rect_h    (rect_h),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .area_sum  (area_sum),
        .status    (status)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // The gap drawn with a beat is spent with valid low after that beat is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                integral_step(cur_beat);
            end
            if (!(in_valid && !in_ready))
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pixel_query_queue.size() != 0)
                begin
                    cur_beat = pixel_query_queue.pop_front();
                    func <= cur_beat.fn;
                    pixel <= cur_beat.pix;
                    rect_x <= cur_beat.x;
                    rect_y <= cur_beat.y;
                    rect_w <= cur_beat.w;
                    rect_h <= cur_beat.h;
                    in_valid <= 1'b1;
                    send_gap <= steady_flow ? 0 : $urandom_range(0, 7);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_check
        area_result_t want;
        int unsigned  hold;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_stall <= 0;
        end
        else if (out_valid && out_ready)
        begin
            if (pending_sums.size() == 0)
            begin
                flag_mismatch("result beat with no query waiting", area_sum, 32'(status));
            end
            else
            begin
                want = pending_sums.pop_front();
                if (area_sum !== want.sum)
                begin
                    flag_mismatch("area_sum", area_sum, want.sum);
                end
                if (status !== want.stat)
                begin
                    flag_mismatch("status", 32'(status), 32'(want.stat));
                end
            end
            hold = steady_flow ? 0 : $urandom_range(0, 7);
            recv_stall <= hold;
            out_ready <= (hold == 0);
        end
        else if (recv_stall != 0)
        begin
            recv_stall <= recv_stall - 1;
            out_ready <= (recv_stall == 1);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    initial
    begin
        int unsigned phase_no;
        dim_t        wr;
        dim_t        hr;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Nothing is loaded yet under the reset size of 256 by 256.
        push_query(9'd0, 9'd0, 9'd0, 9'd0);
        push_query(9'd256, 9'd256, 9'd256, 9'd256);
        push_load(16'hFFFF);
        push_load(16'h0000);
        push_query(9'd0, 9'd0, 9'd1, 9'd1);

        // A register write abandons the partial image above.
        reconfigure(9'd2, 9'd2);
        push_load(16'hFFFF);
        push_load(16'h0000);
        push_load(16'hFFFF);
        push_load(16'hA5A5);
        push_query(9'd0, 9'd0, 9'd2, 9'd2);
        push_query(9'd1, 9'd1, 9'd1, 9'd1);
        push_query(9'd0, 9'd0, 9'd0, 9'd2);
        push_query(9'd2, 9'd2, 9'd0, 9'd0);
        push_query(9'd1, 9'd0, 9'd2, 9'd1);
        push_query(9'd0, 9'd1, 9'd1, 9'd2);
        push_query(9'd256, 9'd0, 9'd0, 9'd0);
        push_query(9'd0, 9'd0, 9'd256, 9'd256);
        push_load(16'h1234);
        push_query(9'd0, 9'd0, 9'd1, 9'd1);

        counting_random = 1'b1;
        phase_no = 0;
        while (random_item_count < RANDOM_ITEMS)
        begin
            if (phase_no == 1)
            begin
                wr = 9'h1FF;
                hr = 9'd0;
            end
            else if (phase_no == 4)
            begin
                wr = 9'd0;
                hr = 9'd400;
            end
            else
            begin
                wr = ($urandom_range(0, 7) == 0) ? dim_t'(0) : dim_t'($urandom_range(1, 8));
                hr = ($urandom_range(0, 7) == 0) ? dim_t'(0) : dim_t'($urandom_range(1, 8));
            end
            reconfigure(wr, hr);
            steady_flow = (phase_no % 5 == 3);
            run_phase(dim_in_use(wr, MAX_WIDTH), dim_in_use(hr, MAX_HEIGHT), phase_no == 2);
            phase_no++;
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* files.f */
rtl/core/sat_pkg.sv
rtl/core/sat_ram.sv
rtl/core/sat_ctrl.sv
rtl/core/sat_datapath.sv
rtl/core/summed_area_table_unit.sv
tb/summed_area_table_unit_test.sv
